// ===== sv/sbrr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo bus response receiver package
// Shared constants, codes and the result record of the servo bus receiver.
// ----------------------------------------------------------------------------
package sbrr_pkg;

    // Input item commands.
    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_WRITE = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_TIMEOUT        = 2'd0;
    localparam logic [1:0] REG_WRITE_INTERVAL = 2'd1;
    localparam logic [1:0] REG_MAX_ID         = 2'd2;

    // Read outcome codes.
    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_TIMEOUT  = 2'd1;
    localparam logic [1:0] ERR_CHECKSUM = 2'd2;
    localparam logic [1:0] ERR_FRAME    = 2'd3;

    // Bus modes, as shown on the bus_phase output.
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_WRITE = 2'd2;

    // Protocol bytes.
    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] ACK_LEN   = 8'h02;
    localparam logic [7:0] STATUS_OK = 8'h00;

    // Tick counters saturate at this value.
    localparam logic [16:0] CNT_MAX = 17'h1FFFF;

    // Register reset values.
    localparam logic [15:0] TIMEOUT_RESET        = 16'd2000;
    localparam logic [15:0] WRITE_INTERVAL_RESET = 16'd1000;
    localparam logic [7:0]  MAX_ID_RESET         = 8'd6;
    localparam logic [7:0]  REQUEST_ID_RESET     = 8'd1;

    // One result transaction.
    typedef struct packed {
        logic        accepted;
        logic        report_valid;
        logic [1:0]  outcome;
        logic [15:0] position;
        logic [1:0]  bus_phase;
    } result_t;

    function automatic logic [16:0] sat_inc(input logic [16:0] v);
        sat_inc = (v == CNT_MAX) ? CNT_MAX : v + 17'd1;
    endfunction

endpackage

// ===== sv/servo_bus_response_receiver.sv =====
// ----------------------------------------------------------------------------
// Servo bus response receiver
// Tracks half-duplex servo bus read and write transactions and deframes the
// FF FF id len body status replies into read outcomes.
// ----------------------------------------------------------------------------
// Each input transaction is a received bus byte, a one microsecond tick, a
// read request or a write request, selected by s_cmd; every input
// transaction produces exactly one result transaction, in order. The block
// takes one input transaction per clock while not stalled: all its work is
// done in combinational logic from the tracker and deframer state to the
// next state and to a two-entry result buffer (an output register with a
// skid register behind it). The input side therefore keeps accepting while a
// result waits on m_ready, and stalls only once both result entries are
// full. Read requests are refused while a read is pending or the bus is
// in write mode; write requests are refused while the bus is in read mode or when
// fewer than write_interval_ticks ticks have passed since the last accepted
// write. Ids outside 1..max_id are refused. A reply frame of six bytes with
// length byte 2 acknowledges the write; any other completed frame reports a
// read outcome (position or error), even if no read was pending. Ticks age
// open transactions; once elapsed ticks exceed timeout_ticks the transaction
// is dropped; a dropped read is reported as a timeout. Configuration registers
// are written through cfg_we/cfg_index/cfg_data by the user, only while the
// block is idle (not enforced); indexes beyond the register list are ignored.
// ----------------------------------------------------------------------------
module servo_bus_response_receiver
    import sbrr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_target_id,

    // Result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_accepted,
    output logic        m_report_valid,
    output logic [1:0]  m_outcome,
    output logic [15:0] m_position,
    output logic [1:0]  m_bus_phase
);

    // Deframer phases. Codes beyond the last member behave as the first.
    typedef enum logic [2:0] {
        PH_H1   = 3'd0,
        PH_H2   = 3'd1,
        PH_ID   = 3'd2,
        PH_LEN  = 3'd3,
        PH_BODY = 3'd4
    } rx_phase_t;

    // Configuration registers.
    logic [15:0] timeout_reg;
    logic [15:0] write_interval_reg;
    logic [7:0]  max_id_reg;

    // Deframer state.
    rx_phase_t   rx_phase_reg, rx_phase_next;
    logic [7:0]  frame_id_reg, frame_id_next;
    logic [7:0]  declared_len_reg, declared_len_next;
    logic [8:0]  frame_count_reg, frame_count_next;
    logic [7:0]  running_sum_reg, running_sum_next;
    logic [7:0]  status_byte_reg, status_byte_next;
    logic [7:0]  pos_low_reg, pos_low_next;
    logic [7:0]  pos_high_reg, pos_high_next;

    // Transaction tracker state.
    logic [7:0]  request_id_reg, request_id_next;
    logic        read_pending_reg, read_pending_next;
    logic        write_pending_reg, write_pending_next;
    logic [1:0]  bus_mode_reg, bus_mode_next;
    logic [16:0] read_elapsed_reg, read_elapsed_next;
    logic [16:0] write_elapsed_reg, write_elapsed_next;
    logic [16:0] since_write_reg, since_write_next;

    // Result buffer: output register and skid register.
    logic        out_valid_reg;
    result_t     out_data_reg;
    logic        skid_valid_reg;
    result_t     skid_data_reg;

    logic        in_fire;
    logic        out_fire;
    result_t     res;

    // Helpers of the byte path.
    logic        id_ok;
    logic [8:0]  count_inc;
    logic [8:0]  frame_end;

    // A new transaction can always be taken while the skid entry is free.
    assign s_ready  = !skid_valid_reg;
    assign in_fire  = s_valid && s_ready;
    assign out_fire = out_valid_reg && m_ready;

    assign id_ok     = (s_target_id != 8'd0) && (s_target_id <= max_id_reg);
    assign count_inc = frame_count_reg + 9'd1;
    assign frame_end = {1'b0, declared_len_reg} + 9'd4;

    // Next state and result of one input transaction.
    always_comb begin
        rx_phase_next      = rx_phase_reg;
        frame_id_next      = frame_id_reg;
        declared_len_next  = declared_len_reg;
        frame_count_next   = frame_count_reg;
        running_sum_next   = running_sum_reg;
        status_byte_next   = status_byte_reg;
        pos_low_next       = pos_low_reg;
        pos_high_next      = pos_high_reg;
        request_id_next    = request_id_reg;
        read_pending_next  = read_pending_reg;
        write_pending_next = write_pending_reg;
        bus_mode_next      = bus_mode_reg;
        read_elapsed_next  = read_elapsed_reg;
        write_elapsed_next = write_elapsed_reg;
        since_write_next   = since_write_reg;

        res              = '0;
        res.accepted     = 1'b1;

        unique case (s_cmd)
            CMD_BYTE: begin
                unique case (rx_phase_reg)
                    PH_H2: begin
                        rx_phase_next = (s_rx_byte == HDR_BYTE) ? PH_ID : PH_H1;
                    end
                    PH_ID: begin
                        frame_id_next    = s_rx_byte;
                        running_sum_next = s_rx_byte;
                        rx_phase_next    = PH_LEN;
                    end
                    PH_LEN: begin
                        declared_len_next = s_rx_byte;
                        running_sum_next  = running_sum_reg + s_rx_byte;
                        frame_count_next  = 9'd4;
                        rx_phase_next     = PH_BODY;
                    end
                    PH_BODY: begin
                        frame_count_next = count_inc;
                        if (count_inc == 9'd5) begin
                            status_byte_next = s_rx_byte;
                        end else if (count_inc == 9'd6) begin
                            pos_low_next = s_rx_byte;
                        end else if (count_inc == 9'd7) begin
                            pos_high_next = s_rx_byte;
                        end
                        if (count_inc >= frame_end) begin
                            // Last byte is the checksum: the frame is complete.
                            rx_phase_next = PH_H1;
                            if (count_inc == 9'd6 && declared_len_reg == ACK_LEN) begin
                                // Write acknowledge.
                                write_pending_next = 1'b0;
                                bus_mode_next      = MODE_IDLE;
                            end else begin
                                res.report_valid  = 1'b1;
                                read_pending_next = 1'b0;
                                bus_mode_next     = MODE_IDLE;
                                if (count_inc < 9'd6) begin
                                    res.outcome = ERR_FRAME;
                                end else if (frame_id_reg != request_id_reg) begin
                                    res.outcome = ERR_FRAME;
                                end else if (s_rx_byte != ~running_sum_reg) begin
                                    res.outcome = ERR_CHECKSUM;
                                end else if (status_byte_next != STATUS_OK) begin
                                    res.outcome = ERR_FRAME;
                                end else if (count_inc < 9'd8) begin
                                    res.outcome = ERR_FRAME;
                                end else begin
                                    res.outcome  = ERR_OK;
                                    res.position = {pos_high_next, pos_low_next};
                                end
                            end
                        end else begin
                            running_sum_next = running_sum_reg + s_rx_byte;
                        end
                    end
                    default: begin
                        rx_phase_next = (s_rx_byte == HDR_BYTE) ? PH_H2 : PH_H1;
                    end
                endcase
            end
            CMD_TICK: begin
                since_write_next = sat_inc(since_write_reg);
                if (read_pending_reg) begin
                    read_elapsed_next = sat_inc(read_elapsed_reg);
                end
                if (write_pending_reg) begin
                    write_elapsed_next = sat_inc(write_elapsed_reg);
                end
                // The read timeout is the one reported when both expire together.
                if (read_pending_reg && read_elapsed_next > {1'b0, timeout_reg}) begin
                    res.report_valid  = 1'b1;
                    res.outcome       = ERR_TIMEOUT;
                    read_pending_next = 1'b0;
                    bus_mode_next     = MODE_IDLE;
                    rx_phase_next     = PH_H1;
                end
                if (write_pending_reg && write_elapsed_next > {1'b0, timeout_reg}) begin
                    write_pending_next = 1'b0;
                    bus_mode_next      = MODE_IDLE;
                    rx_phase_next      = PH_H1;
                end
            end
            CMD_READ: begin
                if (id_ok && !read_pending_reg && bus_mode_reg != MODE_WRITE) begin
                    request_id_next   = s_target_id;
                    read_pending_next = 1'b1;
                    read_elapsed_next = '0;
                    bus_mode_next     = MODE_READ;
                end else begin
                    res.accepted = 1'b0;
                end
            end
            CMD_WRITE: begin
                if (id_ok && since_write_reg >= {1'b0, write_interval_reg}
                        && bus_mode_reg != MODE_READ) begin
                    since_write_next   = '0;
                    write_elapsed_next = '0;
                    write_pending_next = 1'b1;
                    bus_mode_next      = MODE_WRITE;
                    rx_phase_next      = PH_H1;
                    frame_count_next   = '0;
                end else begin
                    res.accepted = 1'b0;
                end
            end
            default: begin
                res.accepted = 1'b1;
            end
        endcase

        res.bus_phase = bus_mode_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg        <= TIMEOUT_RESET;
            write_interval_reg <= WRITE_INTERVAL_RESET;
            max_id_reg         <= MAX_ID_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TIMEOUT:        timeout_reg        <= cfg_data;
                REG_WRITE_INTERVAL: write_interval_reg <= cfg_data;
                REG_MAX_ID:         max_id_reg         <= cfg_data[7:0];
                default: begin
                    // Writes beyond the register list have no effect.
                end
            endcase
        end
    end

    // Tracker and deframer state, updated once per accepted transaction.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_phase_reg      <= PH_H1;
            frame_id_reg      <= '0;
            declared_len_reg  <= '0;
            frame_count_reg   <= '0;
            running_sum_reg   <= '0;
            status_byte_reg   <= '0;
            pos_low_reg       <= '0;
            pos_high_reg      <= '0;
            request_id_reg    <= REQUEST_ID_RESET;
            read_pending_reg  <= 1'b0;
            write_pending_reg <= 1'b0;
            bus_mode_reg      <= MODE_IDLE;
            read_elapsed_reg  <= '0;
            write_elapsed_reg <= '0;
            since_write_reg   <= CNT_MAX;
        end else if (in_fire) begin
            rx_phase_reg      <= rx_phase_next;
            frame_id_reg      <= frame_id_next;
            declared_len_reg  <= declared_len_next;
            frame_count_reg   <= frame_count_next;
            running_sum_reg   <= running_sum_next;
            status_byte_reg   <= status_byte_next;
            pos_low_reg       <= pos_low_next;
            pos_high_reg      <= pos_high_next;
            request_id_reg    <= request_id_next;
            read_pending_reg  <= read_pending_next;
            write_pending_reg <= write_pending_next;
            bus_mode_reg      <= bus_mode_next;
            read_elapsed_reg  <= read_elapsed_next;
            write_elapsed_reg <= write_elapsed_next;
            since_write_reg   <= since_write_next;
        end
    end

    // Result buffer. A new result goes to the output register when it is
    // empty or being drained, else it waits in the skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (out_fire) begin
                if (skid_valid_reg) begin
                    out_data_reg   <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else if (in_fire) begin
                    out_data_reg <= res;
                end else begin
                    out_valid_reg <= 1'b0;
                end
            end else if (in_fire) begin
                if (!out_valid_reg) begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= res;
                end else begin
                    skid_valid_reg <= 1'b1;
                    skid_data_reg  <= res;
                end
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_accepted     = out_data_reg.accepted;
    assign m_report_valid = out_data_reg.report_valid;
    assign m_outcome      = out_data_reg.outcome;
    assign m_position     = out_data_reg.position;
    assign m_bus_phase    = out_data_reg.bus_phase;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo bus response receiver testbench
// Drives byte, tick, read and write transactions into the receiver with random
// gaps and result stalls, and predicts every result with a cycle-free model of
// the transaction tracker and the status reply deframer.
// ----------------------------------------------------------------------------
module tb_top;
    import sbrr_pkg::*;

    // Watchdog limit in cycles without any accepted input or result transaction.
    // The longest quiet stretch of a correct run is one long sender gap or
    // receiver stall plus a register write pause.
    localparam int QUIET_LIMIT = 3000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] rx_byte;
        logic [7:0] target_id;
    } bus_item_t;

    // Deframer phases of the predictor.
    typedef enum logic [2:0] {
        RX_HDR1,
        RX_HDR2,
        RX_ID,
        RX_LEN,
        RX_BODY
    } rx_phase_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = REG_TIMEOUT;
    logic [15:0] cfg_data = 16'd0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = CMD_TICK;
    logic [7:0]  s_rx_byte = 8'd0;
    logic [7:0]  s_target_id = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_accepted;
    logic        m_report_valid;
    logic [1:0]  m_outcome;
    logic [15:0] m_position;
    logic [1:0]  m_bus_phase;

    servo_bus_response_receiver dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_rx_byte      (s_rx_byte),
        .s_target_id    (s_target_id),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_accepted     (m_accepted),
        .m_report_valid (m_report_valid),
        .m_outcome      (m_outcome),
        .m_position     (m_position),
        .m_bus_phase    (m_bus_phase)
    );

    always #6 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor state: a private copy of the registers, of the deframer and of
    // the transaction tracker. It advances once per accepted input transaction.
    // ------------------------------------------------------------------------
    logic [15:0] cfg_timeout     = TIMEOUT_RESET;
    logic [15:0] cfg_wr_interval = WRITE_INTERVAL_RESET;
    logic [7:0]  cfg_max_id      = MAX_ID_RESET;

    rx_phase_t   rx_ph     = RX_HDR1;
    logic [7:0]  fr_id     = 8'd0;
    logic [7:0]  fr_len    = 8'd0;
    logic [8:0]  fr_count  = 9'd0;
    logic [7:0]  fr_sum    = 8'd0;
    logic [7:0]  fr_status = 8'd0;
    logic [7:0]  fr_pos_lo = 8'd0;
    logic [7:0]  fr_pos_hi = 8'd0;
    logic [7:0]  req_id    = REQUEST_ID_RESET;
    logic        rd_open   = 1'b0;
    logic        wr_open   = 1'b0;
    logic [1:0]  link_mode = MODE_IDLE;
    logic [16:0] rd_age    = 17'd0;
    logic [16:0] wr_age    = 17'd0;
    // Starts saturated so that the very first write is never held back.
    logic [16:0] wr_spacing = CNT_MAX;

    // Coverage tallies for the closing summary.
    int outcomes_by_code[4];
    int requests_taken   = 0;
    int requests_refused = 0;
    int acks_seen        = 0;

    bus_item_t pending_items[$];
    result_t   expected_results[$];
    int        items_queued  = 0;
    int        items_sent    = 0;
    int        results_seen  = 0;
    int        mismatch_count = 0;

    function automatic logic [16:0] bump_age(input logic [16:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 17'd1;
    endfunction

    // Advances the predictor by one input transaction and returns the result
    // transaction the receiver must produce for it.
    function automatic result_t servo_link_step(input bus_item_t it);
        result_t    r;
        logic       id_ok;
        logic [7:0] rxb;
        r          = '0;
        r.accepted = 1'b1;
        rxb        = it.rx_byte;
        id_ok      = (it.target_id != 8'd0) && (it.target_id <= cfg_max_id);
        case (it.cmd)
            CMD_BYTE: begin
                case (rx_ph)
                    RX_HDR2: rx_ph = (rxb == HDR_BYTE) ? RX_ID : RX_HDR1;
                    RX_ID: begin
                        fr_id  = rxb;
                        fr_sum = rxb;
                        rx_ph  = RX_LEN;
                    end
                    RX_LEN: begin
                        fr_len   = rxb;
                        fr_sum   = fr_sum + rxb;
                        fr_count = 9'd4;
                        rx_ph    = RX_BODY;
                    end
                    RX_BODY: begin
                        fr_count = fr_count + 9'd1;
                        if (fr_count == 9'd5)
                            fr_status = rxb;
                        else if (fr_count == 9'd6)
                            fr_pos_lo = rxb;
                        else if (fr_count == 9'd7)
                            fr_pos_hi = rxb;
                        if (int'(fr_count) >= int'(fr_len) + 4) begin
                            // The byte just taken is the checksum and ends the frame.
                            rx_ph = RX_HDR1;
                            if (fr_count == 9'd6 && fr_len == ACK_LEN) begin
                                // Write acknowledge: no id or checksum test at all.
                                wr_open   = 1'b0;
                                link_mode = MODE_IDLE;
                                acks_seen++;
                            end else begin
                                // Every other frame is a read outcome, wanted or not.
                                r.report_valid = 1'b1;
                                if (fr_count < 9'd6)
                                    r.outcome = ERR_FRAME;
                                else if (fr_id != req_id)
                                    r.outcome = ERR_FRAME;
                                else if (rxb != ~fr_sum)
                                    r.outcome = ERR_CHECKSUM;
                                else if (fr_status != STATUS_OK)
                                    r.outcome = ERR_FRAME;
                                else if (fr_count < 9'd8)
                                    r.outcome = ERR_FRAME;
                                else
                                    r.outcome = ERR_OK;
                                rd_open   = 1'b0;
                                link_mode = MODE_IDLE;
                            end
                        end else begin
                            fr_sum = fr_sum + rxb;
                        end
                    end
                    default: rx_ph = (rxb == HDR_BYTE) ? RX_HDR2 : RX_HDR1;
                endcase
            end
            CMD_TICK: begin
                wr_spacing = bump_age(wr_spacing);
                if (rd_open)
                    rd_age = bump_age(rd_age);
                if (wr_open)
                    wr_age = bump_age(wr_age);
                // A read timeout is reported; a write timeout only clears state.
                if (rd_open && rd_age > cfg_timeout) begin
                    r.report_valid = 1'b1;
                    r.outcome      = ERR_TIMEOUT;
                    rd_open        = 1'b0;
                    link_mode      = MODE_IDLE;
                    rx_ph          = RX_HDR1;
                end
                if (wr_open && wr_age > cfg_timeout) begin
                    wr_open   = 1'b0;
                    link_mode = MODE_IDLE;
                    rx_ph     = RX_HDR1;
                end
            end
            CMD_READ: begin
                // A taken read leaves the deframer where it is.
                if (id_ok && !rd_open && link_mode != MODE_WRITE) begin
                    req_id    = it.target_id;
                    rd_open   = 1'b1;
                    rd_age    = 17'd0;
                    link_mode = MODE_READ;
                end else begin
                    r.accepted = 1'b0;
                end
            end
            default: begin
                // A taken write restarts the deframer, even inside a write wait.
                if (id_ok && wr_spacing >= cfg_wr_interval && link_mode != MODE_READ) begin
                    wr_spacing = 17'd0;
                    wr_age     = 17'd0;
                    wr_open    = 1'b1;
                    link_mode  = MODE_WRITE;
                    rx_ph      = RX_HDR1;
                    fr_count   = 9'd0;
                end else begin
                    r.accepted = 1'b0;
                end
            end
        endcase
        if (r.report_valid && r.outcome == ERR_OK)
            r.position = {fr_pos_hi, fr_pos_lo};
        r.bus_phase = link_mode;
        if (r.report_valid)
            outcomes_by_code[r.outcome]++;
        if (it.cmd == CMD_READ || it.cmd == CMD_WRITE) begin
            if (r.accepted)
                requests_taken++;
            else
                requests_refused++;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Idle lengths shared by both sides: mostly short, a few long, and now and
    // then a calm stretch of several dozen transactions with no idling at all.
    // ------------------------------------------------------------------------
    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: presents queued items one by one. The valid stays high across
    // back-to-back transactions, and the payload only changes once the current
    // transaction has been accepted. The prediction is made at acceptance,
    // against whatever register setting is in force at that moment.
    // ------------------------------------------------------------------------
    bus_item_t drv_item = '0;
    int        drv_gap  = 0;
    int        drv_calm = 0;

    always @(posedge aclk) begin : drive_items
        logic holding;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            holding = s_valid;
            if (s_valid && s_ready) begin
                expected_results.push_back(servo_link_step(drv_item));
                items_sent++;
                drv_gap = pick_idle(drv_calm);
                holding = 1'b0;
            end
            if (!holding) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    drv_item    = pending_items.pop_front();
                    s_valid     <= 1'b1;
                    s_cmd       <= drv_item.cmd;
                    s_rx_byte   <= drv_item.rx_byte;
                    s_target_id <= drv_item.target_id;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: takes result transactions under random stalls and checks each
    // against the oldest prediction still waiting. Results are printed as
    // accepted/report_valid/outcome/position/bus_phase.
    // ------------------------------------------------------------------------
    int mon_stall = 0;
    int mon_calm  = 0;

    always @(posedge aclk) begin : check_results
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                got = {m_accepted, m_report_valid, m_outcome, m_position, m_bus_phase};
                results_seen++;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected: got %0b/%0b/%0d/%h/%0d",
                             $time, got.accepted, got.report_valid, got.outcome,
                             got.position, got.bus_phase);
                end else begin
                    want = expected_results.pop_front();
                    if (got.accepted !== want.accepted || got.report_valid !== want.report_valid ||
                        got.outcome !== want.outcome || got.position !== want.position ||
                        got.bus_phase !== want.bus_phase) begin
                        mismatch_count++;
                        $display("%0t: result %0d expected %0b/%0b/%0d/%h/%0d, got %0b/%0b/%0d/%h/%0d",
                                 $time, results_seen, want.accepted, want.report_valid,
                                 want.outcome, want.position, want.bus_phase,
                                 got.accepted, got.report_valid, got.outcome,
                                 got.position, got.bus_phase);
                    end
                end
                mon_stall = pick_idle(mon_calm);
            end
            if (mon_stall > 0) begin
                mon_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog: a run that stops moving is a failure.
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: watchdog: no transaction for %0d cycles, %0d results outstanding",
                     $time, QUIET_LIMIT, expected_results.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus builders.
    // ------------------------------------------------------------------------
    task automatic add_item(input logic [1:0] cmd, input logic [7:0] rxb,
                            input logic [7:0] id);
        bus_item_t it;
        it.cmd       = cmd;
        it.rx_byte   = rxb;
        it.target_id = id;
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Byte and tick transactions carry random values in the unused fields.
    task automatic add_byte(input logic [7:0] rxb);
        add_item(CMD_BYTE, rxb, 8'($urandom_range(0, 255)));
    endtask

    task automatic add_ticks(input int n);
        for (int i = 0; i < n; i++)
            add_item(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // Queues a complete status reply. Lengths 0 and 1 still carry one body
    // byte, which is then the checksum. A stray tick may land inside a frame.
    task automatic add_frame(input logic [7:0] id, input logic [7:0] len,
                             input logic [7:0] status, input logic [15:0] pos,
                             input logic corrupt, input logic sprinkle);
        int         nbody;
        logic [7:0] sum;
        logic [7:0] b;
        add_byte(HDR_BYTE);
        add_byte(HDR_BYTE);
        add_byte(id);
        add_byte(len);
        sum   = id + len;
        nbody = (len < 8'd2) ? 1 : int'(len);
        for (int k = 0; k < nbody; k++) begin
            if (sprinkle && $urandom_range(0, 19) == 0)
                add_ticks(1);
            if (k == nbody - 1) begin
                b = ~sum;
                if (corrupt)
                    b = b ^ 8'($urandom_range(1, 255));
            end else if (k == 0) begin
                b = status;
            end else if (k == 1) begin
                b = pos[7:0];
            end else if (k == 2) begin
                b = pos[15:8];
            end else begin
                b = 8'($urandom_range(0, 255));
            end
            add_byte(b);
            sum = sum + b;
        end
    endtask

    function automatic logic [7:0] pick_id();
        if ($urandom_range(0, 99) < 75)
            return 8'($urandom_range(1, cfg_max_id));
        return 8'($urandom_range(0, 255));
    endfunction

    // Reply lengths: mostly the ones that matter to the checks, a few long.
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 8'd0;
        if (r < 18) return 8'd1;
        if (r < 30) return ACK_LEN;
        if (r < 40) return 8'd3;
        if (r < 75) return 8'd4;
        if (r < 85) return 8'($urandom_range(5, 6));
        if (r < 97) return 8'($urandom_range(7, 12));
        return 8'($urandom_range(13, 255));
    endfunction

    // Random traffic, mostly well-formed request and reply exchanges with
    // random content, plus tick bursts, line noise and cut-off frames.
    task automatic add_random_traffic(input int count);
        int         stop_at;
        int         sel;
        int         n;
        logic [7:0] id;
        stop_at = items_queued + count;
        while (items_queued < stop_at) begin
            sel = $urandom_range(0, 99);
            if (sel < 35) begin
                id = pick_id();
                add_item(CMD_READ, 8'($urandom_range(0, 255)), id);
                if (cfg_timeout < 100 && $urandom_range(0, 99) < 20)
                    add_ticks(int'(cfg_timeout) + $urandom_range(0, 2));
                else
                    add_ticks($urandom_range(0, 3));
                add_frame(($urandom_range(0, 99) < 85) ? id : 8'($urandom_range(0, 255)),
                          pick_len(),
                          ($urandom_range(0, 99) < 85) ? STATUS_OK : 8'($urandom_range(0, 255)),
                          16'($urandom_range(0, 65535)),
                          $urandom_range(0, 99) < 10, 1'b1);
            end else if (sel < 55) begin
                add_item(CMD_WRITE, 8'($urandom_range(0, 255)), pick_id());
                add_ticks($urandom_range(0, 4));
                if ($urandom_range(0, 99) < 80)
                    add_frame(8'($urandom_range(0, 255)), ACK_LEN, 8'($urandom_range(0, 255)),
                              16'($urandom_range(0, 65535)), $urandom_range(0, 99) < 10, 1'b0);
                if (cfg_wr_interval < 100)
                    add_ticks($urandom_range(0, int'(cfg_wr_interval) + 2));
            end else if (sel < 70) begin
                add_ticks(($urandom_range(0, 99) < 70) ? $urandom_range(1, 8)
                                                       : $urandom_range(10, 60));
            end else if (sel < 80) begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    add_byte(($urandom_range(0, 99) < 30) ? HDR_BYTE : 8'($urandom_range(0, 255)));
            end else if (sel < 90) begin
                // A frame cut off after its header, id, length or a few body bytes.
                n = $urandom_range(1, 6);
                add_byte(HDR_BYTE);
                if (n > 1) add_byte(HDR_BYTE);
                if (n > 2) add_byte(pick_id());
                if (n > 3) add_byte(pick_len());
                for (int i = 4; i < n; i++)
                    add_byte(8'($urandom_range(0, 255)));
            end else begin
                add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Callers must write registers only while the receiver is idle (this task
    // does not enforce it), so the predictor copy can be updated at once.
    // ------------------------------------------------------------------------
    task automatic set_register(input logic [1:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_TIMEOUT:        cfg_timeout = value;
            REG_WRITE_INTERVAL: cfg_wr_interval = value;
            REG_MAX_ID:         cfg_max_id = value[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [15:0] timeout, input logic [15:0] interval,
                                  input logic [7:0] max_id);
        set_register(REG_TIMEOUT, timeout);
        set_register(REG_WRITE_INTERVAL, interval);
        set_register(REG_MAX_ID, {8'd0, max_id});
    endtask

    // Waits until every queued item went in and every result came out. The
    // receiver does all its work in the cycle it takes an item, so an empty
    // result queue means that nothing is still under way.
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < 4; i++)
            outcomes_by_code[i] = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings. Ticks before any write run on a saturated write
        // spacing counter. Ids 0 and above the limit are refused, a second
        // read and any write are refused during a read wait, and a good
        // eight-byte reply reports its position.
        add_ticks(2);
        add_item(CMD_READ, 8'h00, 8'd0);
        add_item(CMD_READ, 8'hFF, 8'd7);
        add_item(CMD_WRITE, 8'h00, 8'd255);
        add_item(CMD_READ, 8'h55, 8'd1);
        add_item(CMD_READ, 8'hAA, 8'd2);
        add_item(CMD_WRITE, 8'h00, 8'd3);
        add_frame(8'd1, 8'd4, STATUS_OK, 16'hFF00, 1'b0, 1'b0);
        add_item(CMD_WRITE, 8'hFF, 8'd6);
        add_item(CMD_WRITE, 8'h00, 8'd6);
        add_item(CMD_READ, 8'h00, 8'd6);
        wait_drained();

        // Zero timeout and spacing with a single valid id.
        apply_settings(16'd0, 16'd0, 8'd1);
        // A short unsolicited frame frees the bus while the write stays open;
        // the read then taken times out on the same tick as the write.
        add_item(CMD_WRITE, 8'h00, 8'd1);
        add_frame(8'd1, 8'd0, STATUS_OK, 16'h0000, 1'b0, 1'b0);
        add_item(CMD_READ, 8'h00, 8'd1);
        add_ticks(1);
        // An acknowledge arriving during a read ends the write only.
        add_item(CMD_WRITE, 8'h00, 8'd1);
        add_frame(8'd1, 8'd1, STATUS_OK, 16'h0000, 1'b0, 1'b0);
        add_item(CMD_READ, 8'h00, 8'd1);
        add_frame(8'd9, ACK_LEN, 8'h80, 16'h0000, 1'b1, 1'b0);
        add_ticks(1);
        add_random_traffic(300);
        wait_drained();

        apply_settings(16'd30, 16'd8, 8'd253);
        add_random_traffic(520);
        wait_drained();

        // Largest timeout and spacing: nothing times out and no write is taken.
        apply_settings(16'd65535, 16'd65535, 8'd253);
        add_random_traffic(200);
        wait_drained();

        apply_settings(16'd5, 16'd3, 8'd6);
        add_random_traffic(370);
        wait_drained();

        $display("%0d transactions, five settings: %0d requests taken, %0d refused, %0d acks.",
                 items_sent, requests_taken, requests_refused, acks_seen);
        $display("Read outcomes: %0d ok, %0d timeout, %0d checksum, %0d framing, id or servo.",
                 outcomes_by_code[ERR_OK], outcomes_by_code[ERR_TIMEOUT],
                 outcomes_by_code[ERR_CHECKSUM], outcomes_by_code[ERR_FRAME]);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== servo_bus_response_receiver.f =====
sv/sbrr_pkg.sv
sv/servo_bus_response_receiver.sv
bench/tb_top.sv
